[rtl/swbet_pkg.sv]
// Package for the swept box entry time block.
// Default parameter values and the fixed field widths; no dependencies.
package swbet_pkg;

	localparam int COORD_WIDTH_DEF    = 16;
	localparam int VEL_FRAC_BITS_DEF  = 8;
	localparam int TIME_FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int SIZE_W = 15;
	localparam int VEL_W  = 24;

endpackage

[rtl/swept_box_entry_time.sv]
// Throughput: one word per cycle when the output is not stalled; three setup
// stages, then a restoring divider with one quotient bit per stage
// (TIME_FRAC_BITS + 1 stages), then the output register.
// The whole pipeline advances while the output register is empty or being taken.
// Reset (arst_n low, asynchronous) clears all valid bits; no data is held across it.
// Swept box entry time: top level. Uses swbet_pkg.
module swept_box_entry_time #(
	parameter int COORD_WIDTH    = swbet_pkg::COORD_WIDTH_DEF,
	parameter int VEL_FRAC_BITS  = swbet_pkg::VEL_FRAC_BITS_DEF,
	parameter int TIME_FRAC_BITS = swbet_pkg::TIME_FRAC_BITS_DEF,
	localparam int IN_BITS = 4 * COORD_WIDTH + 4 * swbet_pkg::SIZE_W + 2 * swbet_pkg::VEL_W,
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_W   = ((TIME_FRAC_BITS + 1 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
	// target_x, target_y, target_w, target_h
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// entry_time
	output logic [OUT_W-1:0] m_axis_tdata,
	// hit
	output logic [0:0]       m_axis_tuser
);
	import swbet_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int VF   = VEL_FRAC_BITS;
	localparam int TF   = TIME_FRAC_BITS;
	localparam int SW   = SIZE_W;
	localparam int VW   = VEL_W;
	localparam int GW   = ((CW > SW) ? CW : SW + 1) + 2;
	localparam int NW   = GW + 1;
	localparam int DW   = VW;
	localparam int PW   = NW + DW + 1;
	localparam int SUMW = ((CW + VF > VW) ? CW + VF : VW) + 2;
	localparam int BRW  = SUMW + 2;
	localparam int AW   = ((NW + VF > DW) ? NW + VF : DW) + 2;
	localparam logic [BRW-1:0] FRAC_MASK = (BRW'(1) << VF) - BRW'(1);

	localparam int O_MX = 0;
	localparam int O_MY = O_MX + CW;
	localparam int O_MW = O_MY + CW;
	localparam int O_MH = O_MW + SW;
	localparam int O_VX = O_MH + SW;
	localparam int O_VY = O_VX + VW;
	localparam int O_TX = O_VY + VW;
	localparam int O_TY = O_TX + CW;
	localparam int O_TW = O_TY + CW;
	localparam int O_TH = O_TW + SW;

	logic ce;
	logic out_valid_q;
	assign ce            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = ce;

	// ---------------- stage 1: broad box edges, gaps, axis rationals
	logic signed [CW-1:0] m_a  [2];
	logic        [SW-1:0] mw_a [2];
	logic signed [VW:0]   v_a  [2];
	logic signed [CW-1:0] t_a  [2];
	logic        [SW-1:0] tw_a [2];

	logic signed [BRW-1:0] lo_c [2];
	logic signed [BRW-1:0] hi_c [2];
	logic signed [NW-1:0]  ne_c [2];
	logic signed [NW-1:0]  nx_c [2];
	logic        [DW-1:0]  den_c [2];
	logic                  zero_c [2];

	logic signed [BRW-1:0] lo_s1 [2];
	logic signed [BRW-1:0] hi_s1 [2];
	logic signed [BRW-1:0] t_s1  [2];
	logic signed [BRW-1:0] te_s1 [2];
	logic signed [NW-1:0]  ne_s1 [2];
	logic signed [NW-1:0]  nx_s1 [2];
	logic        [DW-1:0]  den_s1 [2];
	logic                  zero_s1 [2];
	logic                  valid_s1;

	always_comb begin
		logic signed [BRW-1:0] sum;
		logic signed [BRW-1:0] flr;
		logic signed [BRW-1:0] vb;
		logic signed [BRW-1:0] avb;
		logic signed [VW:0]    av;
		logic signed [GW-1:0]  m_end;
		logic signed [GW-1:0]  t_end;
		logic signed [GW-1:0]  ge;
		logic signed [GW-1:0]  gx;
		m_a[0]  = $signed(s_axis_tdata[O_MX +: CW]);
		m_a[1]  = $signed(s_axis_tdata[O_MY +: CW]);
		mw_a[0] = s_axis_tdata[O_MW +: SW];
		mw_a[1] = s_axis_tdata[O_MH +: SW];
		v_a[0]  = $signed({s_axis_tdata[O_VX + VW - 1], s_axis_tdata[O_VX +: VW]});
		// vertical axis runs the other way
		v_a[1]  = -$signed({s_axis_tdata[O_VY + VW - 1], s_axis_tdata[O_VY +: VW]});
		t_a[0]  = $signed(s_axis_tdata[O_TX +: CW]);
		t_a[1]  = $signed(s_axis_tdata[O_TY +: CW]);
		tw_a[0] = s_axis_tdata[O_TW +: SW];
		tw_a[1] = s_axis_tdata[O_TH +: SW];
		for (int a = 0; a < 2; a++) begin
			vb  = $signed(BRW'(v_a[a]));
			sum = ($signed(BRW'(m_a[a])) <<< VF) + vb;
			flr = sum >>> VF;
			// truncate toward zero
			if (v_a[a] > 0)
				lo_c[a] = $signed(BRW'(m_a[a]));
			else if (sum < 0 && (sum & FRAC_MASK) != '0)
				lo_c[a] = flr + BRW'(1);
			else
				lo_c[a] = flr;
			av  = v_a[a][VW] ? -v_a[a] : v_a[a];
			avb = $signed(BRW'({1'b0, av[VW-1:0]}));
			hi_c[a] = lo_c[a] + $signed(BRW'({1'b0, mw_a[a]})) + (avb >>> VF);
			m_end = $signed(GW'(m_a[a])) + $signed(GW'({1'b0, mw_a[a]}));
			t_end = $signed(GW'(t_a[a])) + $signed(GW'({1'b0, tw_a[a]}));
			if (v_a[a] > 0) begin
				ge = $signed(GW'(t_a[a])) - m_end;
				gx = t_end - $signed(GW'(m_a[a]));
			end else begin
				ge = t_end - $signed(GW'(m_a[a]));
				gx = $signed(GW'(t_a[a])) - m_end;
			end
			ne_c[a]   = v_a[a][VW] ? -$signed(NW'(ge)) : $signed(NW'(ge));
			nx_c[a]   = v_a[a][VW] ? -$signed(NW'(gx)) : $signed(NW'(gx));
			den_c[a]  = av[VW-1:0];
			zero_c[a] = (v_a[a] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int a = 0; a < 2; a++) begin
				lo_s1[a]   <= lo_c[a];
				hi_s1[a]   <= hi_c[a];
				t_s1[a]    <= $signed(BRW'(t_a[a]));
				te_s1[a]   <= $signed(BRW'(t_a[a])) + $signed(BRW'({1'b0, tw_a[a]}));
				ne_s1[a]   <= ne_c[a];
				nx_s1[a]   <= nx_c[a];
				den_s1[a]  <= den_c[a];
				zero_s1[a] <= zero_c[a];
			end
		end
	end

	// ---------------- stage 2: overlap test, cross products, per-axis flags
	logic                 valid_s2;
	logic                 broad_s2;
	logic signed [PW-1:0] p_en_s2, p_ex_s2, q_en_s2, q_ex_s2;
	logic signed [NW-1:0] ne_s2 [2];
	logic signed [NW-1:0] nx_s2 [2];
	logic        [DW-1:0] den_s2 [2];
	logic                 zero_s2 [2];
	logic                 neg_s2 [2];
	logic                 ab1_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			broad_s2 <= !(t_s1[0] > hi_s1[0] || te_s1[0] < lo_s1[0] ||
				t_s1[1] > hi_s1[1] || te_s1[1] < lo_s1[1]);
			p_en_s2 <= $signed(PW'(ne_s1[0])) * $signed(PW'({1'b0, den_s1[1]}));
			p_ex_s2 <= $signed(PW'(nx_s1[0])) * $signed(PW'({1'b0, den_s1[1]}));
			q_en_s2 <= $signed(PW'(ne_s1[1])) * $signed(PW'({1'b0, den_s1[0]}));
			q_ex_s2 <= $signed(PW'(nx_s1[1])) * $signed(PW'({1'b0, den_s1[0]}));
			for (int a = 0; a < 2; a++) begin
				ne_s2[a]   <= ne_s1[a];
				nx_s2[a]   <= nx_s1[a];
				den_s2[a]  <= den_s1[a];
				zero_s2[a] <= zero_s1[a];
				neg_s2[a]  <= zero_s1[a] || ne_s1[a] < 0;
				ab1_s2[a]  <= !zero_s1[a] &&
					(($signed(AW'(ne_s1[a])) <<< VF) > $signed(AW'({1'b0, den_s1[a]})));
			end
		end
	end

	// ---------------- stage 3: pick entry/exit, decide, load divider
	logic                 en_x, ex_x, en_gt_ex, ok_c;
	logic signed [NW-1:0] nsel;
	logic signed [AW-1:0] nshift;

	always_comb begin
		if (zero_s2[1])
			en_x = 1'b1;
		else if (zero_s2[0])
			en_x = 1'b0;
		else
			en_x = p_en_s2 >= q_en_s2;
		if (zero_s2[1])
			ex_x = 1'b1;
		else if (zero_s2[0])
			ex_x = 1'b0;
		else
			ex_x = p_ex_s2 <= q_ex_s2;
		unique case ({en_x, ex_x})
			2'b11:   en_gt_ex = ne_s2[0] > nx_s2[0];
			2'b00:   en_gt_ex = ne_s2[1] > nx_s2[1];
			2'b10:   en_gt_ex = p_en_s2 > q_ex_s2;
			default: en_gt_ex = q_en_s2 > p_ex_s2;
		endcase
		nsel   = en_x ? ne_s2[0] : ne_s2[1];
		nshift = $signed(AW'(nsel)) <<< VF;
		ok_c   = broad_s2 && !en_gt_ex && !(neg_s2[0] && neg_s2[1]) &&
			!ab1_s2[0] && !ab1_s2[1] && !(zero_s2[0] && zero_s2[1]) && nsel >= 0;
	end

	logic          valid_s3;
	logic          ok_s3;
	logic [DW:0]   rem_s3;
	logic [DW-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ok_s3  <= ok_c;
			rem_s3 <= nshift[DW:0];
			den_s3 <= en_x ? den_s2[0] : den_s2[1];
		end
	end

	// ---------------- divider: one quotient bit per stage, integer bit first
	logic          div_valid_s [TF+1];
	logic          div_ok_s    [TF+1];
	logic [DW:0]   div_rem_s   [TF+1];
	logic [DW-1:0] div_den_s   [TF+1];
	logic [TF:0]   div_quo_s   [TF+1];

	for (genvar k = 0; k <= TF; k++) begin : g_div
		logic          vin, okin;
		logic [DW-1:0] din;
		logic [TF:0]   qin;
		logic [DW:0]   rtry;
		logic          take;
		if (k == 0) begin : g_first
			assign vin  = valid_s3;
			assign okin = ok_s3;
			assign din  = den_s3;
			assign qin  = '0;
			assign rtry = rem_s3;
		end else begin : g_next
			logic [DW:0] rin;
			assign vin  = div_valid_s[k-1];
			assign okin = div_ok_s[k-1];
			assign din  = div_den_s[k-1];
			assign qin  = div_quo_s[k-1];
			assign rin  = div_rem_s[k-1];
			assign rtry = {rin[DW-1:0], 1'b0};
		end
		assign take = rtry >= {1'b0, din};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (ce) begin
				div_valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				div_ok_s[k]  <= okin;
				div_den_s[k] <= din;
				div_rem_s[k] <= take ? rtry - {1'b0, din} : rtry;
				div_quo_s[k] <= qin | ((TF+1)'(take) << (TF - k));
			end
		end
	end

	// ---------------- output register
	logic [TF:0] time_q;
	logic        hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ce) begin
			out_valid_q <= div_valid_s[TF];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// quotient never exceeds one full step here
			time_q <= div_ok_s[TF] ? div_quo_s[TF] : {1'b1, {TF{1'b0}}};
			hit_q  <= div_ok_s[TF] && !div_quo_s[TF][TF];
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = OUT_W'(time_q);
	assign m_axis_tuser[0] = hit_q;

endmodule

[rtl/swbet_chk.sv]
// Port-level checker for swept_box_entry_time, bound to the top level.
// Depends on the top level's port list and parameters only.
module swbet_chk #(
	parameter int OUT_W = 24,
	parameter int TF    = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic [0:0]       m_axis_tuser
);

	// a stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// entry time saturates at one full step
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[TF] && (m_axis_tdata[TF-1:0] != '0)))
		else $error("entry time above one step");

	// hit flag agrees with the time word
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] == !m_axis_tdata[TF])
		else $error("hit flag inconsistent with entry time");

	// input side is ready whenever the output can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

endmodule

bind swept_box_entry_time swbet_chk #(
	.OUT_W(OUT_W),
	.TF(TIME_FRAC_BITS)
) u_swbet_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

[verif/swbet_checker.sv]
// Checker for the swept box entry time block: watches both stream channels,
// predicts entry time and hit for every accepted input word, compares results.
// Depends on swbet_pkg for the field widths.
module swbet_checker #(
	parameter int IN_W  = 176,
	parameter int OUT_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	input  logic             s_ready,
	input  logic [IN_W-1:0]  s_data,
	input  logic             m_valid,
	input  logic             m_ready,
	input  logic [OUT_W-1:0] m_data,
	input  logic [0:0]       m_user,
	output int               pending,
	output int               errors
);
	import swbet_pkg::*;

	localparam int  VFRAC = VEL_FRAC_BITS_DEF;
	localparam int  TFRAC = TIME_FRAC_BITS_DEF;
	localparam longint FULL = longint'(1) << TFRAC;

	typedef struct {
		int     kind;   // -1 minus infinity, 0 finite, +1 plus infinity
		longint num;
		longint den;
	} span_t;

	typedef struct {
		logic [OUT_W-1:0] entry_time;
		logic             hit;
	} contact_t;

	contact_t contact_q[$];

	function automatic int span_cmp(span_t a, span_t b);
		longint l, r;
		if (a.kind != b.kind)
			return a.kind < b.kind ? -1 : 1;
		if (a.kind != 0)
			return 0;
		l = a.num * b.den;
		r = b.num * a.den;
		return l < r ? -1 : (l > r ? 1 : 0);
	endfunction

	function automatic bit sweep_overlaps(longint m, longint mw, longint v, longint t,
		longint tw);
		longint one, b, av, bw;
		one = longint'(1) << VFRAC;
		b   = (v > 0) ? m : (m * one + v) / one;
		av  = v < 0 ? -v : v;
		bw  = mw + av / one;
		return !(t > b + bw || t + tw < b);
	endfunction

	function automatic void axis_span(longint m, longint mw, longint v, longint t,
		longint tw, output span_t en, output span_t ex);
		longint ge, gx;
		if (v > 0) begin
			ge = t - (m + mw);
			gx = (t + tw) - m;
		end else begin
			ge = (t + tw) - m;
			gx = t - (m + mw);
		end
		if (v == 0) begin
			en = '{-1, 0, 1};
			ex = '{1, 0, 1};
		end else if (v < 0) begin
			en = '{0, -ge, -v};
			ex = '{0, -gx, -v};
		end else begin
			en = '{0, ge, v};
			ex = '{0, gx, v};
		end
	endfunction

	function automatic bit span_neg(span_t a);
		return a.kind < 0 || (a.kind == 0 && a.num < 0);
	endfunction

	function automatic bit span_past_step(span_t a);
		return a.kind == 0 && a.num * (longint'(1) << VFRAC) > a.den;
	endfunction

	function automatic contact_t predict_contact(logic [IN_W-1:0] d);
		longint mx, my, mw, mh, vx, vy, tx, ty, tw, th, q;
		span_t enx, exx, eny, exy, en, ex;
		contact_t c;
		mx = longint'($signed(d[15:0]));
		my = longint'($signed(d[31:16]));
		mw = longint'(d[46:32]);
		mh = longint'(d[61:47]);
		vx = longint'($signed(d[85:62]));
		vy = -longint'($signed(d[109:86]));
		tx = longint'($signed(d[125:110]));
		ty = longint'($signed(d[141:126]));
		tw = longint'(d[156:142]);
		th = longint'(d[171:157]);
		q  = FULL;
		if (sweep_overlaps(mx, mw, vx, tx, tw) && sweep_overlaps(my, mh, vy, ty, th)) begin
			axis_span(mx, mw, vx, tx, tw, enx, exx);
			axis_span(my, mh, vy, ty, th, eny, exy);
			en = span_cmp(enx, eny) >= 0 ? enx : eny;
			ex = span_cmp(exx, exy) <= 0 ? exx : exy;
			if (!(span_cmp(en, ex) > 0 || (span_neg(enx) && span_neg(eny)) ||
				span_past_step(enx) || span_past_step(eny)) && en.kind == 0 && en.num >= 0) begin
				q = (en.num * (longint'(1) << VFRAC) * FULL) / en.den;
				if (q > FULL)
					q = FULL;
			end
		end
		c.entry_time = OUT_W'(q);
		c.hit        = q < FULL;
		return c;
	endfunction

	assign pending = contact_q.size();

	initial errors = 0;

	always @(posedge clk) begin
		contact_t e;
		if (arst_n) begin
			if (s_valid && s_ready)
				contact_q.push_back(predict_contact(s_data));
			if (m_valid && m_ready) begin
				if (contact_q.size() == 0) begin
					$error("result word with nothing expected: entry_time=%0d hit=%0d",
						m_data, m_user);
					errors++;
				end else begin
					e = contact_q.pop_front();
					if (m_data !== e.entry_time) begin
						$error("entry_time: expected %0d, got %0d", e.entry_time, m_data);
						errors++;
					end
					if (m_user[0] !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, m_user[0]);
						errors++;
					end
				end
			end
		end
	end
endmodule

[verif/tb_top.sv]
// Testbench top for swept_box_entry_time: clock, reset, directed and random stimulus
// in idle and stall phases, and the verdict. Uses swbet_pkg and the swbet_checker module.
module tb_top;
	import swbet_pkg::*;

	localparam int IN_W  = 176;
	localparam int OUT_W = 24;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [15:0] mx, my;
		logic [14:0]        mw, mh;
		logic signed [23:0] vx, vy;
		logic signed [15:0] tx, ty;
		logic [14:0]        tw, th;
	} box_pair_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0]       m_axis_tuser;
	int               pending, errors;
	int               src_idle_pct = 0, sink_stall_pct = 0;
	int               cycles = 0;

	always #6 clk = ~clk;

	swept_box_entry_time u_dut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	swbet_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
		.clk, .arst_n,
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
		.m_user(m_axis_tuser), .pending, .errors
	);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL swept_box_entry_time");
			$finish;
		end
	end

	function automatic box_pair_t pair_of(int mx, int my, int mw, int mh, int vx, int vy,
		int tx, int ty, int tw, int th);
		box_pair_t p;
		p.mx = 16'(mx); p.my = 16'(my); p.mw = 15'(mw); p.mh = 15'(mh);
		p.vx = 24'(vx); p.vy = 24'(vy);
		p.tx = 16'(tx); p.ty = 16'(ty); p.tw = 15'(tw); p.th = 15'(th);
		return p;
	endfunction

	// sender-side word; tready is sampled at the falling edge before the acceptance edge
	task automatic send_pair(box_pair_t p);
		bit rdy;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, p.th, p.tw, p.ty, p.tx, p.vy, p.vx, p.mh, p.mw, p.my, p.mx};
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
	endtask

	function automatic box_pair_t random_pair();
		int tx, ty;
		if ($urandom_range(99) < 20)
			return pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		// boxes near each other with moderate velocity so contacts are common
		tx = int'($urandom_range(4000)) - 2000;
		ty = int'($urandom_range(4000)) - 2000;
		return pair_of(tx + int'($urandom_range(1200)) - 600,
			ty + int'($urandom_range(1200)) - 600,
			$urandom_range(300), $urandom_range(300),
			int'($urandom_range(200000)) - 100000, int'($urandom_range(200000)) - 100000,
			tx, ty, $urandom_range(300), $urandom_range(300));
	endfunction

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		box_pair_t dir[$];
		int idle_set[4];
		int stall_set[4];
		idle_set  = '{0, 74, 0, 24};
		stall_set = '{0, 0, 74, 24};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// approach from the left, exact hit at half a step
		dir.push_back(pair_of(0, 0, 10, 10, 20 << 8, 0, 20, 0, 10, 10));
		// approach from the right and from below (vertical velocity is negated)
		dir.push_back(pair_of(100, 0, 10, 10, -(80 << 8), 0, 0, 0, 20, 10));
		dir.push_back(pair_of(0, 50, 10, 10, 0, 60 << 8, 0, 0, 10, 10));
		// zero velocity while overlapping: both entries minus infinity
		dir.push_back(pair_of(0, 0, 10, 10, 0, 0, 5, 5, 10, 10));
		// broad phase miss
		dir.push_back(pair_of(0, 0, 10, 10, 1 << 8, 0, 500, 0, 10, 10));
		// entry later than one step, touching edge exactly at end
		dir.push_back(pair_of(0, 0, 10, 10, 5 << 8, 0, 16, 0, 10, 10));
		dir.push_back(pair_of(0, 0, 10, 10, 6 << 8, 0, 16, 0, 10, 10));
		// fractional velocity, truncation of the broad edge
		dir.push_back(pair_of(-3, 0, 4, 4, -383, 0, -6, 0, 1, 4));
		// entry past exit (diagonal miss)
		dir.push_back(pair_of(0, 0, 2, 2, 40 << 8, -(40 << 8), 30, -2, 2, 2));
		// degenerate boxes
		dir.push_back(pair_of(0, 0, 0, 0, 10 << 8, 0, 5, 0, 0, 0));
		// most negative and most positive vertical velocity
		dir.push_back(pair_of(0, 0, 10, 10, 0, -8388608, 0, 100, 10, 10));
		dir.push_back(pair_of(0, 0, 10, 10, 0, 8388607, 0, -20000, 10, 10));
		// field extremes
		dir.push_back(pair_of(-32768, -32768, 32767, 32767, 8388607, -8388608,
			32767, 32767, 32767, 32767));
		dir.push_back(pair_of(32767, 32767, 32767, 32767, -8388608, 8388607,
			-32768, -32768, 32767, 32767));
		dir.push_back(pair_of(-32768, 32767, 0, 0, -8388608, -8388608,
			32767, -32768, 0, 0));
		dir.push_back(pair_of(0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
		dir.push_back(pair_of(-1, -1, 1, 1, -1, -1, -1, -1, 1, 1));
		foreach (dir[i])
			send_pair(dir[i]);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = idle_set[ph];
			sink_stall_pct = stall_set[ph];
			for (int n = 0; n < 240; n++) begin
				maybe_idle();
				send_pair(random_pair());
			end
			drain();
		end

		sink_stall_pct = 0;
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("PASS swept_box_entry_time");
		else
			$display("FAIL swept_box_entry_time");
		$finish;
	end
endmodule
